// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Define SYNTH to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check prop on every clk_i edge outside reset.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check prop on every clk_i edge, reset included.
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // Bitmap row width: blocks examined per scan step.
  localparam int WORD_W     = 16;
  localparam int WORD_SHIFT = 4;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_RELEASE = 2'd2
  } bba_cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LOOKUP
  } bba_state_e;

  typedef struct packed {
    bba_cmd_e    cmd;
    logic [7:0]  blk_num;
  } bba_req_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  result_block;
    logic [8:0]  used_count;
    logic [7:0]  free_count;
  } bba_rsp_t;

  // Result of the find-first-zero unit.
  typedef struct packed {
    logic                  found;
    logic [WORD_SHIFT-1:0] bit_idx;
  } bba_ffz_t;

endpackage

`default_nettype wire

// ===== rtl/core/bba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bba_ffz.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Find the lowest clear bit of one bitmap row, skipping blocks at or above LIMIT.
module bba_ffz
  import bba_pkg::*;
#(
  parameter int ROW_W = 4,
  parameter int LIMIT = 255
) (
  input  wire logic [WORD_W-1:0] word_i,
  input  wire logic [ROW_W-1:0]  row_i,
  output bba_ffz_t               res_o
);

  logic [31:0]       base;
  logic [WORD_W-1:0] usable;

  assign base = 32'(row_i) << WORD_SHIFT;

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      usable[j] = (base + 32'(j)) < 32'(LIMIT);
    end
  end

  // Scan from the top so the lowest hit wins.
  always_comb begin
    res_o = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (!word_i[j] && usable[j]) begin
        res_o.found   = 1'b1;
        res_o.bit_idx = WORD_SHIFT'(j);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_block_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Allocate reads and searches the bitmap rows from row 0 up, stopping at the first
//   free block or after LAST_ROW. Request and release read the row, then update it
//   and answer; an out-of-range id or unused code answers from idle. One command at a time.
// Rate is set by the bitmap RAM: one 16-bit row is read and searched per cycle.
// Reset: the counters clear at once, then a pass zeroes the bitmap one row a cycle
//   with busy high; done_o cannot be stalled.
`include "assert_macros.svh"

module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS    = 256,
  parameter int USABLE_BLOCKS = 255
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire bba_req_t req_i,
  output logic          done_o,
  output bba_rsp_t      rsp_o
);

  // Geometry of the bitmap store.
  localparam int ROWS     = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LIMIT    = (USABLE_BLOCKS < NUM_BLOCKS) ? USABLE_BLOCKS : NUM_BLOCKS;
  localparam int LAST_ROW = (LIMIT - 1) / WORD_W;
  localparam int CNT_W    = $clog2(NUM_BLOCKS + 1);
  localparam int FW       = CNT_W + 9;

  bba_state_e state_q, state_d;
  bba_req_t   req_q, req_d;
  logic [ROW_W-1:0] row_q, row_d;   // clear pointer / row under test
  logic [CNT_W-1:0] used_q, used_d;
  logic             done_q, done_d;
  bba_rsp_t         rsp_q, rsp_d;

  logic              ram_we, ram_re;
  logic [ROW_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  bba_ffz_t          ffz;

  logic              new_in_range;
  logic [ROW_W-1:0]  new_row, held_row;
  logic [WORD_SHIFT-1:0] held_bit;
  logic [ROW_W+11:0] alloc_blk;
  logic [FW-1:0]     used_ext, free_ext;

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Search the row returned by the RAM this cycle.
  bba_ffz #(
    .ROW_W (ROW_W),
    .LIMIT (LIMIT)
  ) u_ffz (
    .word_i (ram_rdata),
    .row_i  (row_q),
    .res_o  (ffz)
  );

  assign new_in_range = 32'(req_i.blk_num) < 32'(LIMIT);
  assign new_row      = ROW_W'({{ROW_W{1'b0}}, req_i.blk_num} >> WORD_SHIFT);
  assign held_row     = ROW_W'({{ROW_W{1'b0}}, req_q.blk_num} >> WORD_SHIFT);
  assign held_bit     = req_q.blk_num[WORD_SHIFT-1:0];
  assign alloc_blk    = {8'b0, row_q, ffz.bit_idx};

  // Free count after this command, saturating at zero.
  assign used_ext = FW'(used_d);
  assign free_ext = (used_ext + FW'(1) >= FW'(NUM_BLOCKS)) ? '0
                  : FW'(NUM_BLOCKS) - used_ext - FW'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (row_q == ROW_W'(ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (req_i.cmd)
            CMD_ALLOC: state_d = ST_SCAN;
            CMD_REQUEST, CMD_RELEASE: begin
              if (new_in_range) begin
                state_d = ST_LOOKUP;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (ffz.found || row_q == ROW_W'(LAST_ROW)) begin
          state_d = ST_IDLE;
        end
      end
      ST_LOOKUP: state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    req_d     = req_q;
    row_d     = row_q;
    used_d    = used_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = row_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = row_q;

    unique case (state_q)
      ST_CLEAR: begin
        // Zero one row a cycle.
        ram_we = 1'b1;
        if (row_q != ROW_W'(ROWS - 1)) begin
          row_d = row_q + ROW_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          unique case (req_i.cmd)
            CMD_ALLOC: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              row_d     = '0;
            end
            CMD_REQUEST, CMD_RELEASE: begin
              if (new_in_range) begin
                ram_re    = 1'b1;
                ram_raddr = new_row;
              end else begin
                done_d             = 1'b1;
                rsp_d.ok           = 1'b0;
                rsp_d.result_block = req_i.blk_num;
              end
            end
            default: begin
              // Unused code: fail, echo the id and report counts.
              done_d             = 1'b1;
              rsp_d.ok           = 1'b0;
              rsp_d.result_block = req_i.blk_num;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (ffz.found) begin
          // Mark the hit and report it.
          ram_we             = 1'b1;
          ram_waddr          = row_q;
          ram_wdata          = ram_rdata | (WORD_W'(1) << ffz.bit_idx);
          used_d             = used_q + CNT_W'(1);
          done_d             = 1'b1;
          rsp_d.ok           = 1'b1;
          rsp_d.result_block = alloc_blk[7:0];
        end else if (row_q == ROW_W'(LAST_ROW)) begin
          done_d             = 1'b1;
          rsp_d.ok           = 1'b0;
          rsp_d.result_block = '0;
        end else begin
          // Advance: the next row is read while this one is searched.
          ram_re    = 1'b1;
          ram_raddr = row_q + ROW_W'(1);
          row_d     = row_q + ROW_W'(1);
        end
      end
      ST_LOOKUP: begin
        done_d             = 1'b1;
        rsp_d.result_block = req_q.blk_num;
        rsp_d.ok           = 1'b0;
        ram_waddr          = held_row;
        if (req_q.cmd == CMD_REQUEST && !ram_rdata[held_bit]) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (WORD_W'(1) << held_bit);
          used_d    = used_q + CNT_W'(1);
          rsp_d.ok  = 1'b1;
        end else if (req_q.cmd == CMD_RELEASE && ram_rdata[held_bit]) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(WORD_W'(1) << held_bit);
          used_d    = used_q - CNT_W'(1);
          rsp_d.ok  = 1'b1;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase

    if (done_d) begin
      rsp_d.used_count = used_ext[8:0];
      rsp_d.free_count = free_ext[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      row_q   <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Never mark more blocks than can be handed out.
  `BBA_ASSERT(a_used_bound, 32'(used_q) <= 32'(LIMIT), "used count above usable limit")
  // An accepted word either starts work or answers in the next cycle.
  `BBA_ASSERT(a_accept_progress, (start && !busy) |=> (busy || done_o), "accepted word lost")
  // A failed command leaves the used count alone.
  `BBA_ASSERT(a_fail_no_change, (done_o && !rsp_o.ok) |-> (used_q == $past(used_q)),
              "used count moved on a failed command")
  // A successful command moves the used count.
  `BBA_ASSERT(a_ok_changes, (done_o && rsp_o.ok) |-> (used_q != $past(used_q)),
              "ok reported without a count change")
  // The bitmap is written only by the sequencer, never while idle.
  `BBA_ASSERT_ALWAYS(a_no_idle_write, !(ram_we && state_q == ST_IDLE),
                     "bitmap written while idle")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench
  import bba_pkg::*;
();

  localparam int NUM_BLOCKS    = 256;
  localparam int USABLE_BLOCKS = 255;
  // Code 3 is not an enum member; the block must treat it as a no-op.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Slowest word: the longest sender gap plus a full-map scan miss, and the bitmap
  // clearing pass after reset. Take it many times over.
  localparam int STALL_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 24;
  localparam int RANDOM_WORDS  = 1050;
  localparam int MAX_PRINTS    = 40;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  bba_req_t req_i  = '0;
  logic     busy;
  logic     done_o;
  bba_rsp_t rsp_o;

  // Shadow copy of the allocator state, advanced as each word is accepted.
  bit [NUM_BLOCKS-1:0] used_map;
  int unsigned         used_total;
  bba_rsp_t            pending_rsp_q[$];

  int unsigned mismatch_count = 0;
  int unsigned words_sent     = 0;
  int unsigned idle_cycles    = 0;
  // Chance in percent that the sender pauses before a word.
  int unsigned gap_pct        = 0;

  bitmap_block_allocator_unit #(
    .NUM_BLOCKS   (NUM_BLOCKS),
    .USABLE_BLOCKS(USABLE_BLOCKS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one command to the shadow bitmap and return the response it should give.
  function automatic bba_rsp_t apply_cmd(input logic [1:0] code, input logic [7:0] id);
    bba_rsp_t r;
    bit       hit;
    r.ok           = 1'b0;
    r.result_block = id;
    hit            = 1'b0;
    case (code)
      CMD_ALLOC: begin
        // First fit: lowest free block below the usable limit, or zero on a miss.
        r.result_block = '0;
        for (int i = 0; i < USABLE_BLOCKS; i++) begin
          if (!hit && !used_map[i]) begin
            hit            = 1'b1;
            used_map[i]    = 1'b1;
            used_total++;
            r.ok           = 1'b1;
            r.result_block = i[7:0];
          end
        end
      end
      CMD_REQUEST: begin
        if (id < USABLE_BLOCKS && !used_map[id]) begin
          used_map[id] = 1'b1;
          used_total++;
          r.ok         = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (id < USABLE_BLOCKS && used_map[id]) begin
          used_map[id] = 1'b0;
          used_total--;
          r.ok         = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.used_count = used_total[8:0];
    // One block is reserved; clamp at zero when the map is full.
    if (used_total + 1 >= NUM_BLOCKS) r.free_count = '0;
    else r.free_count = 8'(NUM_BLOCKS - used_total - 1);
    return r;
  endfunction

  // Random block in the given state, scanning from a random point; falls back to
  // a random id when no block is in that state.
  function automatic logic [7:0] pick_block(input bit want_used);
    int base;
    int b;
    base = $urandom_range(0, USABLE_BLOCKS - 1);
    for (int k = 0; k < USABLE_BLOCKS; k++) begin
      b = (base + k) % USABLE_BLOCKS;
      if (used_map[b] == want_used) return b[7:0];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Send one command word. Called at a rising edge; start stays high when the
  // next word follows without a gap, so it is never dropped and raised in one step.
  task automatic send_word(input logic [1:0] code, input logic [7:0] id);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{cmd: bba_cmd_e'(code), blk_num: id};
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    // Accepted at this edge: advance the shadow state and queue the response.
    pending_rsp_q.push_back(apply_cmd(code, id));
    words_sent++;
  endtask

  // Hit every command and the edges of the id range on a near-empty map.
  task automatic test_directed();
    gap_pct = 30;
    send_word(CMD_REQUEST, 8'd0);        // claim a free block
    send_word(CMD_REQUEST, 8'd0);        // claim a block already in use
    send_word(CMD_REQUEST, 8'd255);      // id past the usable limit
    send_word(CMD_REQUEST, 8'd254);      // highest usable block
    send_word(CMD_RELEASE, 8'd255);      // release past the usable limit
    send_word(CMD_RELEASE, 8'd254);
    send_word(CMD_RELEASE, 8'd254);      // release a block already free
    send_word(CMD_UNUSED, 8'hAA);        // unused code echoes the id
    send_word(CMD_UNUSED, 8'h55);
    send_word(CMD_ALLOC, 8'hFF);         // id is ignored on allocate
    send_word(CMD_ALLOC, 8'h00);
    send_word(CMD_ALLOC, 8'h5A);
    send_word(CMD_RELEASE, 8'd2);
    send_word(CMD_ALLOC, 8'hA5);         // reuse the hole just opened
    send_word(CMD_REQUEST, 8'd128);
    send_word(CMD_RELEASE, 8'd128);
    send_word(CMD_RELEASE, 8'd0);
    send_word(CMD_ALLOC, 8'h0F);
    send_word(CMD_REQUEST, 8'd15);       // row boundary
    send_word(CMD_REQUEST, 8'd16);
    send_word(CMD_RELEASE, 8'd1);
    send_word(CMD_RELEASE, 8'd3);
  endtask

  // Fill the map to the usable limit, hit allocate on a full map, then drain it.
  task automatic test_fill_drain();
    int unsigned sel;
    gap_pct = 20;
    while (used_total < USABLE_BLOCKS) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) send_word(CMD_ALLOC, 8'($urandom));
      else if (sel < 80) send_word(CMD_REQUEST, pick_block(1'b0));
      else if (sel < 88) send_word(CMD_REQUEST, 8'($urandom));
      else if (sel < 96) send_word(CMD_RELEASE, pick_block(1'b1));
      else send_word(CMD_UNUSED, 8'($urandom));
    end
    // Map full: allocate and request must fail without changing anything.
    repeat (3) send_word(CMD_ALLOC, 8'($urandom));
    send_word(CMD_REQUEST, pick_block(1'b1));
    send_word(CMD_REQUEST, 8'd255);
    send_word(CMD_RELEASE, 8'd255);
    gap_pct = 40;
    while (used_total > 0) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) send_word(CMD_RELEASE, pick_block(1'b1));
      else if (sel < 82) send_word(CMD_RELEASE, 8'($urandom));
      else if (sel < 92) send_word(CMD_ALLOC, 8'($urandom));
      else if (sel < 97) send_word(CMD_REQUEST, 8'($urandom));
      else send_word(CMD_UNUSED, 8'($urandom));
    end
    // Empty map: release of a free block fails.
    send_word(CMD_RELEASE, 8'($urandom_range(0, USABLE_BLOCKS - 1)));
  endtask

  // Mixed traffic around a half-full map; the last stretch runs without gaps.
  task automatic test_mixed();
    int unsigned sel;
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent + 150 >= RANDOM_WORDS) gap_pct = 0;
      else gap_pct = (words_sent / 64) % 2 ? 0 : 35;
      sel = $urandom_range(0, 99);
      if (sel < 30) send_word(CMD_ALLOC, 8'($urandom));
      else if (sel < 45) send_word(CMD_REQUEST, pick_block(1'b0));
      else if (sel < 55) send_word(CMD_REQUEST, 8'($urandom));
      else if (sel < 80) send_word(CMD_RELEASE, pick_block(1'b1));
      else if (sel < 92) send_word(CMD_RELEASE, 8'($urandom));
      else send_word(2'($urandom), 8'($urandom));
    end
  endtask

  // Compare every response with the oldest expectation, field by field.
  always @(posedge clk_i) begin
    bba_rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected response, block", rsp_o.result_block, -1);
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_o.ok !== want.ok)
          report_mismatch("ok", rsp_o.ok, want.ok);
        if (rsp_o.result_block !== want.result_block)
          report_mismatch("result_block", rsp_o.result_block, want.result_block);
        if (rsp_o.used_count !== want.used_count)
          report_mismatch("used_count", rsp_o.used_count, want.used_count);
        if (rsp_o.free_count !== want.free_count)
          report_mismatch("free_count", rsp_o.free_count, want.free_count);
      end
    end
  end

  // Watchdog: end the run when nothing is accepted or answered for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("bitmap_block_allocator_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    used_map   = '0;
    used_total = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill_drain();
    test_mixed();
    start <= 1'b0;
    // Drain outstanding responses, then hold a little longer for stray strobes.
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("bitmap_block_allocator_unit test passed");
    end else begin
      $display("bitmap_block_allocator_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_ffz.sv
rtl/core/bitmap_block_allocator_unit.sv
tb/testbench.sv
